>>> hdl/mpx2rgba_pkg.sv
package mpx2rgba_pkg;

  localparam int PIX_W     = 32;
  localparam int CHAN_W    = 8;
  localparam int COLOR_W   = 24;
  localparam int IDX_W     = 8;
  localparam int BPP_W     = 3;
  localparam int SHIFT_W   = 5;
  localparam int RUN_W     = 6;
  localparam int CFG_IDX_W = 3;

  localparam int LAT       = 6;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);
  localparam int FQ_DEPTH  = 4;
  localparam int FQ_AW     = $clog2(FQ_DEPTH);
  localparam int FQ_CW     = $clog2(FQ_DEPTH + 1);

  localparam int SUM_W     = 13;
  localparam int MAG_W     = 22;
  localparam int MAG_SH    = 21;
  localparam int QP_W      = SUM_W + MAG_W;
  localparam int REM_W     = 7;
  localparam int KC_W      = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPP   = 3'd0,
    CFG_RED   = 3'd1,
    CFG_GREEN = 3'd2,
    CFG_BLUE  = 3'd3,
    CFG_ALPHA = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_PAL_WRITE,
    KIND_PAL_LOOKUP,
    KIND_CONVERT
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [PIX_W-1:0]     pix;
    logic [IDX_W-1:0]     idx;
    logic [COLOR_W-1:0]   color;
  } fe_item_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_SEEK,
    SC_RUN,
    SC_SKIP
  } scan_state_t;

  typedef struct packed {
    logic               zero;
    logic [SHIFT_W-1:0] sh;
    logic [RUN_W-1:0]   wd;
  } chan_dec_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  // residues of 2^(8k) mod (2^w - 1), reciprocal of 2^w - 1, inverse mod 256
  typedef struct packed {
    logic [KC_W-1:0]   c0;
    logic [KC_W-1:0]   c1;
    logic [KC_W-1:0]   c2;
    logic [KC_W-1:0]   c3;
    logic [MAG_W-1:0]  mag;
    logic [CHAN_W-1:0] inv;
  } div_k_t;

  function automatic div_k_t div_consts(input logic [2:0] w);
    div_k_t k;
    unique case (w)
      3'd1:    k = '{5'd0, 5'd0, 5'd0, 5'd0,  22'd2097152, 8'd1};
      3'd2:    k = '{5'd1, 5'd1, 5'd1, 5'd1,  22'd699051,  8'd171};
      3'd3:    k = '{5'd1, 5'd4, 5'd2, 5'd1,  22'd299594,  8'd183};
      3'd4:    k = '{5'd1, 5'd1, 5'd1, 5'd1,  22'd139811,  8'd239};
      3'd5:    k = '{5'd1, 5'd8, 5'd2, 5'd16, 22'd67651,   8'd223};
      3'd6:    k = '{5'd1, 5'd4, 5'd16, 5'd1, 22'd33289,   8'd191};
      3'd7:    k = '{5'd1, 5'd2, 5'd4, 5'd8,  22'd16514,   8'd127};
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

>>> hdl/mpx2rgba_mask_scan.sv
module mpx2rgba_mask_scan import mpx2rgba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [PIX_W-1:0] mask,
  output chan_dec_t        dec,
  output logic             busy
);

  scan_state_t        state_r, state_nxt;
  logic [SHIFT_W-1:0] bit_r, bit_nxt;
  logic [SHIFT_W-1:0] sh_r, sh_nxt;
  logic [RUN_W-1:0]   wd_r, wd_nxt;
  logic               zero_r, zero_nxt;
  logic               b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_SEEK;
      bit_r   <= '0;
      sh_r    <= '0;
      wd_r    <= '0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
      sh_r    <= sh_nxt;
      wd_r    <= wd_nxt;
      zero_r  <= zero_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    sh_nxt    = sh_r;
    wd_nxt    = wd_r;
    zero_nxt  = zero_r;
    b         = mask[bit_r];
    unique case (state_r)
      SC_IDLE: begin
      end
      SC_SEEK: begin
        if (b) begin
          wd_nxt    = RUN_W'(1);
          state_nxt = SC_RUN;
        end else begin
          sh_nxt = sh_r + SHIFT_W'(1);
        end
      end
      SC_RUN: begin
        if (b) begin
          wd_nxt = wd_r + RUN_W'(1);
        end else begin
          state_nxt = SC_SKIP;
        end
      end
      SC_SKIP: begin
      end
      default: state_nxt = SC_IDLE;
    endcase
    if (state_r != SC_IDLE) begin
      bit_nxt = bit_r + SHIFT_W'(1);
      if (bit_r == '1) begin
        state_nxt = SC_IDLE;
        zero_nxt  = (state_r == SC_SEEK) && !b;
      end
    end
    if (start) begin
      state_nxt = SC_SEEK;
      bit_nxt   = '0;
      sh_nxt    = '0;
      wd_nxt    = '0;
      zero_nxt  = 1'b0;
    end
  end

  assign dec  = '{zero: zero_r, sh: sh_r, wd: wd_r};
  assign busy = (state_r != SC_IDLE);

endmodule

>>> hdl/mpx2rgba_front.sv
module mpx2rgba_front import mpx2rgba_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               hold,
  input  logic               cmd,
  input  logic [PIX_W-1:0]   pix,
  input  logic [IDX_W-1:0]   idx,
  input  logic [COLOR_W-1:0] color,
  input  logic [BPP_W-1:0]   bpp,
  output logic               head_valid,
  output fe_item_t           head,
  input  logic               head_pop
);

  fe_item_t         fq_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wp_r, rp_r;
  logic [FQ_CW-1:0] cnt_r, cnt_nxt;
  logic [PIX_W-1:0] pix_m;
  kind_t            kind;
  logic             keep;
  logic             enq;

  // classify: palette write, palette lookup, masked conversion, or drop
  always_comb begin
    pix_m = pix;
    kind  = KIND_CONVERT;
    keep  = 1'b1;
    if (!cmd) begin
      kind = KIND_PAL_WRITE;
    end else begin
      case (bpp)
        3'd1: begin
          kind  = KIND_PAL_LOOKUP;
          pix_m = {24'd0, pix[7:0]};
        end
        3'd2: pix_m = {16'd0, pix[15:0]};
        3'd3: pix_m = {8'd0, pix[23:0]};
        3'd4: pix_m = pix;
        default: keep = 1'b0;
      endcase
    end
  end

  assign full       = hold || (cnt_r == FQ_CW'(FQ_DEPTH));
  assign enq        = push && !full && keep;
  assign head_valid = (cnt_r != '0);
  assign head       = fq_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (enq && !head_pop) begin
      cnt_nxt = cnt_r + FQ_CW'(1);
    end else if (!enq && head_pop) begin
      cnt_nxt = cnt_r - FQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (enq) begin
        wp_r <= wp_r + FQ_AW'(1);
      end
      if (head_pop) begin
        rp_r <= rp_r + FQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      fq_r[wp_r] <= '{kind: kind, pix: pix_m, idx: idx, color: color};
    end
  end

endmodule

>>> hdl/mpx2rgba_chan.sv
module mpx2rgba_chan import mpx2rgba_pkg::*; (
  input  logic              clk,
  input  logic [PIX_W-1:0]  pix,
  input  logic [PIX_W-1:0]  mask,
  input  chan_dec_t         dec,
  output logic [CHAN_W-1:0] ch
);

  logic [2:0]        wn;
  div_k_t            k;
  logic [REM_W-1:0]  m;
  logic              wide;

  logic [PIX_W-1:0]  v_r, v_nxt;
  logic [PIX_W-1:0]  x_r, x_nxt;
  logic [SUM_W-1:0]  s_r, s_nxt;
  logic [SUM_W-1:0]  s_d_r;
  logic [SUM_W-1:0]  q_r, q_nxt;
  logic [REM_W-1:0]  r_r, r_nxt;
  logic [CHAN_W-1:0] ch_r, ch_nxt;
  logic [CHAN_W-1:0] wres_r [4];
  logic [CHAN_W-1:0] wres_nxt;
  logic [CHAN_W-1:0] xl_r [3];
  logic [QP_W-1:0]   qp;
  logic [SUM_W-1:0]  rdiff;
  logic [CHAN_W-1:0] d;
  logic [15:0]       p;

  assign wn   = dec.wd[2:0];
  assign k    = div_consts(wn);
  assign m    = REM_W'((8'd1 << wn) - 8'd1);
  assign wide = (dec.wd >= RUN_W'(CHAN_W));

  always_comb begin
    v_nxt    = (pix & mask) >> dec.sh;
    wres_nxt = CHAN_W'(v_r >> (dec.wd - RUN_W'(CHAN_W)));
    x_nxt    = (v_r << CHAN_W) - v_r + PIX_W'(m >> 1);
    // x mod (2^w - 1) from byte residues
    s_nxt    = SUM_W'(x_r[7:0]) * SUM_W'(k.c0)
             + SUM_W'(x_r[15:8]) * SUM_W'(k.c1)
             + SUM_W'(x_r[23:16]) * SUM_W'(k.c2)
             + SUM_W'(x_r[31:24]) * SUM_W'(k.c3);
    qp       = QP_W'(s_r) * QP_W'(k.mag);
    q_nxt    = qp[MAG_SH +: SUM_W];
    rdiff    = s_d_r - q_r * SUM_W'(m);
    r_nxt    = rdiff[REM_W-1:0];
    // exact quotient low byte via inverse of odd divisor
    d        = xl_r[2] - CHAN_W'(r_r);
    p        = 16'(d) * 16'(k.inv);
    if (dec.zero) begin
      ch_nxt = '0;
    end else if (wide) begin
      ch_nxt = wres_r[3];
    end else begin
      ch_nxt = p[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    v_r       <= v_nxt;
    x_r       <= x_nxt;
    wres_r[0] <= wres_nxt;
    s_r       <= s_nxt;
    xl_r[0]   <= x_r[CHAN_W-1:0];
    wres_r[1] <= wres_r[0];
    q_r       <= q_nxt;
    s_d_r     <= s_r;
    xl_r[1]   <= xl_r[0];
    wres_r[2] <= wres_r[1];
    r_r       <= r_nxt;
    xl_r[2]   <= xl_r[1];
    wres_r[3] <= wres_r[2];
    ch_r      <= ch_nxt;
  end

  assign ch = ch_r;

endmodule

>>> hdl/mpx2rgba_back.sv
module mpx2rgba_back import mpx2rgba_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  fe_item_t         head,
  output logic             head_pop,
  input  logic [PIX_W-1:0] red_mask,
  input  logic [PIX_W-1:0] green_mask,
  input  logic [PIX_W-1:0] blue_mask,
  input  logic [PIX_W-1:0] alpha_mask,
  input  chan_dec_t        dec_red,
  input  chan_dec_t        dec_green,
  input  chan_dec_t        dec_blue,
  input  chan_dec_t        dec_alpha,
  output logic             empty,
  input  logic             pop,
  output rgba_t            out_item
);

  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  logic [COLOR_W-1:0]       pal_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] pal_vld_r;
  logic [COLOR_W-1:0]       pal_rd_r;
  logic                     hit_r;
  logic [COLOR_W-1:0]       pal_line_r [1:LAT-1];
  logic [LAT-1:0]           vld_r;
  logic [LAT-1:0]           lk_r;
  logic [OUT_CW-1:0]        used_r, used_nxt;

  rgba_t                    of_r [OUT_DEPTH];
  logic [OUT_AW-1:0]        of_wp_r, of_rp_r;
  logic [OUT_CW-1:0]        of_cnt_r, of_cnt_nxt;

  logic                     is_wr;
  logic                     res_issue;
  logic                     wr_in_range;
  logic                     rd_in_range;
  logic [PAL_AW-1:0]        waddr, raddr;
  logic                     of_wr, of_rd;
  rgba_t                    of_wdata;
  logic [CHAN_W-1:0]        ch_red, ch_green, ch_blue, ch_alpha;
  logic [COLOR_W-1:0]       pal_out;

  // issue a result only with a free output slot reserved for every result in flight; palette writes need none
  assign is_wr       = (head.kind == KIND_PAL_WRITE);
  assign head_pop    = head_valid && (is_wr || (used_r != OUT_CW'(OUT_DEPTH)));
  assign res_issue   = head_pop && !is_wr;
  assign wr_in_range = ({1'b0, head.idx} < (IDX_W + 1)'(PALETTE_DEPTH));
  assign rd_in_range = ({1'b0, head.pix[IDX_W-1:0]} < (IDX_W + 1)'(PALETTE_DEPTH));
  assign waddr       = head.idx[PAL_AW-1:0];
  assign raddr       = head.pix[PAL_AW-1:0];

  always_ff @(posedge clk) begin
    if (head_pop && is_wr && wr_in_range) begin
      pal_mem[waddr] <= head.color;
    end
    pal_rd_r <= pal_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_vld_r <= '0;
    end else if (head_pop && is_wr && wr_in_range) begin
      pal_vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    hit_r         <= rd_in_range && pal_vld_r[raddr];
    pal_line_r[1] <= hit_r ? pal_rd_r : '0;
    for (int i = 2; i < LAT; i++) begin
      pal_line_r[i] <= pal_line_r[i-1];
    end
  end

  mpx2rgba_chan u_chan_red (
    .clk (clk), .pix (head.pix), .mask (red_mask), .dec (dec_red), .ch (ch_red)
  );
  mpx2rgba_chan u_chan_green (
    .clk (clk), .pix (head.pix), .mask (green_mask), .dec (dec_green), .ch (ch_green)
  );
  mpx2rgba_chan u_chan_blue (
    .clk (clk), .pix (head.pix), .mask (blue_mask), .dec (dec_blue), .ch (ch_blue)
  );
  mpx2rgba_chan u_chan_alpha (
    .clk (clk), .pix (head.pix), .mask (alpha_mask), .dec (dec_alpha), .ch (ch_alpha)
  );

  assign pal_out = pal_line_r[LAT-1];

  always_comb begin
    if (lk_r[LAT-1]) begin
      of_wdata = '{red: pal_out[23:16], green: pal_out[15:8], blue: pal_out[7:0],
                   alpha: 8'hFF};
    end else begin
      of_wdata = '{red: ch_red, green: ch_green, blue: ch_blue,
                   alpha: dec_alpha.zero ? 8'hFF : ch_alpha};
    end
  end

  assign of_wr = vld_r[LAT-1];
  assign of_rd = pop && !empty;
  assign empty = (of_cnt_r == '0);
  assign out_item = of_r[of_rp_r];

  always_comb begin
    used_nxt = used_r;
    if (res_issue && !of_rd) begin
      used_nxt = used_r + OUT_CW'(1);
    end else if (!res_issue && of_rd) begin
      used_nxt = used_r - OUT_CW'(1);
    end
    of_cnt_nxt = of_cnt_r;
    if (of_wr && !of_rd) begin
      of_cnt_nxt = of_cnt_r + OUT_CW'(1);
    end else if (!of_wr && of_rd) begin
      of_cnt_nxt = of_cnt_r - OUT_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      used_r   <= '0;
      of_wp_r  <= '0;
      of_rp_r  <= '0;
      of_cnt_r <= '0;
    end else begin
      vld_r    <= {vld_r[LAT-2:0], res_issue};
      used_r   <= used_nxt;
      of_cnt_r <= of_cnt_nxt;
      if (of_wr) begin
        of_wp_r <= of_wp_r + OUT_AW'(1);
      end
      if (of_rd) begin
        of_rp_r <= of_rp_r + OUT_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    lk_r <= {lk_r[LAT-2:0], head.kind == KIND_PAL_LOOKUP};
    if (of_wr) begin
      of_r[of_wp_r] <= of_wdata;
    end
  end

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= OUT_CW'(OUT_DEPTH))
    else $error("result credit count above output queue depth");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
    of_cnt_r <= used_r)
    else $error("output queue holds more items than were issued");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    of_wr |-> (of_cnt_r != OUT_CW'(OUT_DEPTH)))
    else $error("pipeline wrote into a full output queue");

endmodule

>>> hdl/masked_pixel_to_rgba8.sv
// masked_pixel_to_rgba8: packed pixel to rgba8 converter
// input queue side: push/full with command, pixel_bytes, palette_index,
//   palette_color; an item is taken when push is high and full is low
// result queue side: empty/pop; red, green, blue, alpha of the oldest result
//   stand on the ports while empty is low, taken when pop is high
// config side: cfg_valid/cfg_ready with cfg_index and cfg_data; ready always
//   high, write only while no item is in flight
// palette writes and pixels with a bad byte count give no result
// throughput: one item per cycle while full is low
// path: the input queue, then the six-stage channel pipeline (shift, scale,
//   residue, reciprocal multiply, remainder, inverse multiply), then the
//   result queue, where empty goes low
// each mask write restarts a bit scan of all masks, one mask bit per
//   cycle; full stays high during the scan
// reset: registers take their defaults, palette reads as zero, queues empty,
//   and the mask scan runs before the first item is taken
// stalls: a 4-item input queue and an 8-item result queue part the two sides;
//   with pop low the pipeline keeps working until the result queue is spoken
//   for, then full rises once the input queue fills
module masked_pixel_to_rgba8 import mpx2rgba_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_command,
  input  logic [PIX_W-1:0]     in_pixel_bytes,
  input  logic [IDX_W-1:0]     in_palette_index,
  input  logic [COLOR_W-1:0]   in_palette_color,
  output logic                 empty,
  input  logic                 pop,
  output logic [CHAN_W-1:0]    out_red,
  output logic [CHAN_W-1:0]    out_green,
  output logic [CHAN_W-1:0]    out_blue,
  output logic [CHAN_W-1:0]    out_alpha,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data
);

  logic [BPP_W-1:0] bpp_r;
  logic [PIX_W-1:0] red_mask_r, green_mask_r, blue_mask_r, alpha_mask_r;
  logic             cfg_we;
  logic             scan_start;
  cfg_idx_t         cfg_idx;
  chan_dec_t        dec_red, dec_green, dec_blue, dec_alpha;
  logic             busy_red, busy_green, busy_blue, busy_alpha;
  logic             scan_busy;
  logic             head_valid, head_pop;
  fe_item_t         head;
  rgba_t            out_item;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_idx   = cfg_idx_t'(cfg_index);

  always_comb begin
    scan_start = 1'b0;
    unique case (cfg_idx) inside
      CFG_RED, CFG_GREEN, CFG_BLUE, CFG_ALPHA: scan_start = cfg_we;
      default: scan_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r        <= BPP_W'(4);
      red_mask_r   <= 32'h00FF_0000;
      green_mask_r <= 32'h0000_FF00;
      blue_mask_r  <= 32'h0000_00FF;
      alpha_mask_r <= 32'hFF00_0000;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_BPP:   bpp_r        <= cfg_data[BPP_W-1:0];
        CFG_RED:   red_mask_r   <= cfg_data;
        CFG_GREEN: green_mask_r <= cfg_data;
        CFG_BLUE:  blue_mask_r  <= cfg_data;
        CFG_ALPHA: alpha_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mpx2rgba_mask_scan u_scan_red (
    .clk (clk), .rst_n (rst_n), .start (scan_start), .mask (red_mask_r),
    .dec (dec_red), .busy (busy_red)
  );
  mpx2rgba_mask_scan u_scan_green (
    .clk (clk), .rst_n (rst_n), .start (scan_start), .mask (green_mask_r),
    .dec (dec_green), .busy (busy_green)
  );
  mpx2rgba_mask_scan u_scan_blue (
    .clk (clk), .rst_n (rst_n), .start (scan_start), .mask (blue_mask_r),
    .dec (dec_blue), .busy (busy_blue)
  );
  mpx2rgba_mask_scan u_scan_alpha (
    .clk (clk), .rst_n (rst_n), .start (scan_start), .mask (alpha_mask_r),
    .dec (dec_alpha), .busy (busy_alpha)
  );

  assign scan_busy = busy_red || busy_green || busy_blue || busy_alpha;

  mpx2rgba_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .hold       (scan_busy),
    .cmd        (in_command),
    .pix        (in_pixel_bytes),
    .idx        (in_palette_index),
    .color      (in_palette_color),
    .bpp        (bpp_r),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  mpx2rgba_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .red_mask   (red_mask_r),
    .green_mask (green_mask_r),
    .blue_mask  (blue_mask_r),
    .alpha_mask (alpha_mask_r),
    .dec_red    (dec_red),
    .dec_green  (dec_green),
    .dec_blue   (dec_blue),
    .dec_alpha  (dec_alpha),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item)
  );

  assign out_red   = out_item.red;
  assign out_green = out_item.green;
  assign out_blue  = out_item.blue;
  assign out_alpha = out_item.alpha;

endmodule

>>> sim/rgba_checker.sv
`timescale 1ns / 1ps

module rgba_checker import mpx2rgba_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 full,
  input  logic                 in_command,
  input  logic [PIX_W-1:0]     in_pixel_bytes,
  input  logic [IDX_W-1:0]     in_palette_index,
  input  logic [COLOR_W-1:0]   in_palette_color,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [CHAN_W-1:0]    out_red,
  input  logic [CHAN_W-1:0]    out_green,
  input  logic [CHAN_W-1:0]    out_blue,
  input  logic [CHAN_W-1:0]    out_alpha,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   awaiting
);

  logic [BPP_W-1:0]   bpp;
  logic [PIX_W-1:0]   mask_r;
  logic [PIX_W-1:0]   mask_g;
  logic [PIX_W-1:0]   mask_b;
  logic [PIX_W-1:0]   mask_a;
  logic [COLOR_W-1:0] pal_copy [PALETTE_DEPTH];
  rgba_t              rgba_due [$];
  int                 fails = 0;

  // cut one channel out by its mask and bring it to 8 bits
  function automatic logic [CHAN_W-1:0] channel8(input logic [PIX_W-1:0] pix,
                                                 input logic [PIX_W-1:0] mask);
    logic [PIX_W-1:0] m;
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] sum;
    int               sh;
    int               w;
    if (mask == '0) return '0;
    m = mask;
    sh = 0;
    w = 0;
    while (m[0] == 1'b0) begin
      m = m >> 1;
      sh++;
    end
    v = (pix & mask) >> sh;
    while (m[0] == 1'b1) begin
      m = m >> 1;
      w++;
    end
    if (w >= 8) return CHAN_W'(v >> (w - 8));
    top = (32'd1 << w) - 32'd1;
    sum = v * 32'd255 + (top >> 1);
    return CHAN_W'(sum / top);
  endfunction

  function automatic bit convert_pixel(input logic [PIX_W-1:0] pix, output rgba_t res);
    logic [COLOR_W-1:0] e;
    logic [PIX_W-1:0]   p;
    res = '0;
    case (bpp)
      3'd1: begin
        e = '0;
        if (int'(pix[7:0]) < PALETTE_DEPTH) e = pal_copy[pix[7:0]];
        res = '{e[23:16], e[15:8], e[7:0], 8'hFF};
        return 1'b1;
      end
      3'd2, 3'd3, 3'd4: begin
        p = pix;
        if (bpp == 3'd2) p = pix & 32'h0000_FFFF;
        if (bpp == 3'd3) p = pix & 32'h00FF_FFFF;
        res.red   = channel8(p, mask_r);
        res.green = channel8(p, mask_g);
        res.blue  = channel8(p, mask_b);
        res.alpha = (mask_a != '0) ? channel8(p, mask_a) : 8'hFF;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    rgba_t calc;
    rgba_t want;
    if (!rst_n) begin
      bpp = 3'd4;
      mask_r = 32'h00FF_0000;
      mask_g = 32'h0000_FF00;
      mask_b = 32'h0000_00FF;
      mask_a = 32'hFF00_0000;
      for (int i = 0; i < PALETTE_DEPTH; i++) pal_copy[i] = '0;
      rgba_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BPP:   bpp = cfg_data[BPP_W-1:0];
          CFG_RED:   mask_r = cfg_data;
          CFG_GREEN: mask_g = cfg_data;
          CFG_BLUE:  mask_b = cfg_data;
          CFG_ALPHA: mask_a = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        if (!in_command) begin
          if (int'(in_palette_index) < PALETTE_DEPTH)
            pal_copy[in_palette_index] = in_palette_color;
        end else if (convert_pixel(in_pixel_bytes, calc)) begin
          rgba_due.push_back(calc);
        end
      end
      if (pop && !empty) begin
        if (rgba_due.size() == 0) begin
          $error("result with nothing expected: %h %h %h %h",
                 out_red, out_green, out_blue, out_alpha);
          fails++;
        end else begin
          want = rgba_due.pop_front();
          if (out_red !== want.red) begin
            $error("red expected %h got %h", want.red, out_red);
            fails++;
          end
          if (out_green !== want.green) begin
            $error("green expected %h got %h", want.green, out_green);
            fails++;
          end
          if (out_blue !== want.blue) begin
            $error("blue expected %h got %h", want.blue, out_blue);
            fails++;
          end
          if (out_alpha !== want.alpha) begin
            $error("alpha expected %h got %h", want.alpha, out_alpha);
            fails++;
          end
        end
      end
    end
    awaiting <= rgba_due.size();
    mismatches <= fails;
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench import mpx2rgba_pkg::*;;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;
  localparam int   QUIET_LIMIT = 5000;
  localparam int   HOLD_CYCLES = 150;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic                 in_command = 1'b0;
  logic [PIX_W-1:0]     in_pixel_bytes = '0;
  logic [IDX_W-1:0]     in_palette_index = '0;
  logic [COLOR_W-1:0]   in_palette_color = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [CHAN_W-1:0]    out_red;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_blue;
  logic [CHAN_W-1:0]    out_alpha;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PIX_W-1:0]     cfg_data = '0;

  int mismatches;
  int awaiting;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;

  wire moved = (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  masked_pixel_to_rgba8 uut (
    .clk, .rst_n, .push, .full, .in_command, .in_pixel_bytes, .in_palette_index,
    .in_palette_color, .empty, .pop, .out_red, .out_green, .out_blue, .out_alpha,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  rgba_checker chk (
    .clk, .rst_n, .push, .full, .in_command, .in_pixel_bytes, .in_palette_index,
    .in_palette_color, .empty, .pop, .out_red, .out_green, .out_blue, .out_alpha,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .mismatches, .awaiting
  );

  // receiver side, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || moved) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[masked_pixel_to_rgba8] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic put_item(input logic cmd, input logic [PIX_W-1:0] pix,
                          input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] col);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_command <= cmd;
    in_pixel_bytes <= pix;
    in_palette_index <= idx;
    in_palette_color <= col;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [PIX_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every result, then for items that leave none
  task automatic drain_pipe();
    push <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_mask();
    int unsigned kind;
    int unsigned w;
    int unsigned sh;
    logic [63:0] run;
    kind = $urandom_range(0, 9);
    if (kind == 0) return '0;
    if (kind == 1) return $urandom;
    if (kind == 2) return '1;
    w = (kind < 6) ? $urandom_range(1, 8) : $urandom_range(1, 32);
    sh = $urandom_range(0, 32 - w);
    run = ((64'd1 << w) - 64'd1) << sh;
    if (kind == 9) return run[31:0] | ($urandom & ~((32'd1 << sh) - 32'd1));
    return run[31:0];
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin tx_gap_pct = 0;  rx_stall_pct <= 0;  end
      1: begin tx_gap_pct = 57; rx_stall_pct <= 0;  end
      2: begin tx_gap_pct = 0;  rx_stall_pct <= 57; end
      default: begin tx_gap_pct = 24; rx_stall_pct <= 24; end
    endcase
  endtask

  initial begin
    logic [BPP_W-1:0] bpp;
    logic             cmd;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset formats
    put_item(CMD_CONVERT, 32'h0000_0000, 8'h00, 24'h000000);
    put_item(CMD_CONVERT, 32'hFFFF_FFFF, 8'hFF, 24'hFFFFFF);
    put_item(CMD_CONVERT, 32'h80FF_017F, 8'h5A, 24'hA55A00);
    put_item(CMD_PALETTE, 32'hFFFF_FFFF, 8'h00, 24'hFFFFFF);
    put_item(CMD_PALETTE, 32'h0000_0000, 8'hFF, 24'h123456);
    drain_pipe();

    // palette lookups, upper pixel bytes ignored
    cfg_write(CFG_BPP, 32'd1);
    put_item(CMD_CONVERT, 32'hFFFF_FF00, 8'h00, 24'h000000);
    put_item(CMD_CONVERT, 32'h0000_00FF, 8'h00, 24'h000000);
    put_item(CMD_CONVERT, 32'h0000_0007, 8'h00, 24'h000000);
    put_item(CMD_PALETTE, 32'h0000_0000, 8'h42, 24'hABCDEF);
    put_item(CMD_CONVERT, 32'h1234_5642, 8'h42, 24'h000000);
    drain_pipe();

    // 565 with no alpha
    cfg_write(CFG_BPP, 32'd2);
    cfg_write(CFG_RED, 32'h0000_F800);
    cfg_write(CFG_GREEN, 32'h0000_07E0);
    cfg_write(CFG_BLUE, 32'h0000_001F);
    cfg_write(CFG_ALPHA, 32'h0000_0000);
    put_item(CMD_CONVERT, 32'h0000_FFFF, 8'h00, 24'h000000);
    put_item(CMD_CONVERT, 32'h0000_0000, 8'h00, 24'h000000);
    put_item(CMD_CONVERT, 32'h0001_2345, 8'h00, 24'h000000);
    drain_pipe();

    // narrow channels
    cfg_write(CFG_BPP, 32'd3);
    cfg_write(CFG_RED, 32'h0000_0003);
    cfg_write(CFG_GREEN, 32'h0000_0F00);
    cfg_write(CFG_BLUE, 32'h007F_0000);
    cfg_write(CFG_ALPHA, 32'h0000_0080);
    put_item(CMD_CONVERT, 32'hFFFF_FFFF, 8'h00, 24'h000000);
    put_item(CMD_CONVERT, 32'h00A5_A5A5, 8'h00, 24'h000000);
    drain_pipe();

    // full-width and gapped masks
    cfg_write(CFG_BPP, 32'd4);
    cfg_write(CFG_RED, 32'hFFFF_FFFF);
    cfg_write(CFG_GREEN, 32'h8000_0001);
    cfg_write(CFG_BLUE, 32'h0F0F_0000);
    cfg_write(CFG_ALPHA, 32'h0000_FFF0);
    put_item(CMD_CONVERT, 32'hFFFF_FFFF, 8'h00, 24'h000000);
    put_item(CMD_CONVERT, 32'h8000_0001, 8'h00, 24'h000000);
    put_item(CMD_CONVERT, 32'h7FFF_FFFE, 8'h00, 24'h000000);
    drain_pipe();

    // bad byte counts give nothing
    cfg_write(CFG_BPP, 32'd0);
    put_item(CMD_CONVERT, 32'h0000_1234, 8'h00, 24'h000000);
    drain_pipe();
    cfg_write(CFG_BPP, 32'd5);
    put_item(CMD_CONVERT, 32'hFFFF_FFFF, 8'h00, 24'h000000);
    drain_pipe();
    cfg_write(CFG_BPP, 32'd6);
    put_item(CMD_CONVERT, 32'h5555_5555, 8'h00, 24'h000000);
    drain_pipe();
    cfg_write(CFG_BPP, 32'd7);
    put_item(CMD_CONVERT, 32'hAAAA_AAAA, 8'h00, 24'h000000);
    put_item(CMD_PALETTE, 32'h0000_0000, 8'h80, 24'h00FF00);
    drain_pipe();

    for (int p = 0; p < 12; p++) begin
      bpp = (p % 6 == 1) ? 3'd1 : BPP_W'($urandom_range(2, 4));
      cfg_write(CFG_BPP, PIX_W'(bpp));
      cfg_write(CFG_RED, pick_mask());
      cfg_write(CFG_GREEN, pick_mask());
      cfg_write(CFG_BLUE, pick_mask());
      cfg_write(CFG_ALPHA, pick_mask());
      set_idling(p % 4);
      if (p == 2) hold_req <= hold_req + 1;
      for (int n = 0; n < 150; n++) begin
        cmd = ($urandom_range(0, 99) < ((bpp == 3'd1) ? 30 : 8)) ? CMD_PALETTE : CMD_CONVERT;
        put_item(cmd, $urandom, IDX_W'($urandom), COLOR_W'($urandom));
      end
      drain_pipe();
    end

    if (mismatches == 0 && awaiting == 0) begin
      $display("[masked_pixel_to_rgba8] OK");
    end else begin
      $display("[masked_pixel_to_rgba8] ERROR");
    end
    $finish;
  end

endmodule
